[rtl/rfa_pkg.sv]
// Package with modes, widths and shared types of the rational fraction ALU.
package rfa_pkg;
    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int WIDE = 64;

    typedef enum logic [2:0] {
        MODE_SIMPLIFY = 3'd0,
        MODE_SCALE    = 3'd1,
        MODE_ADD      = 3'd2,
        MODE_SUB      = 3'd3,
        MODE_MUL      = 3'd4,
        MODE_DIV      = 3'd5
    } mode_t;

    typedef struct packed {
        logic start;
        logic [WIDE-1:0] dividend;
        logic [WIDE-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [WIDE-1:0] quot;
        logic [WIDE-1:0] rem;
    } div_rsp_t;
endpackage

[rtl/rational_fraction_alu_top.sv]
// Top level of the rational fraction ALU: cross products, Euclid gcd, reduction.
// Usage: an input transaction on s_axis carries mode and fractions A and B;
// one result transaction on m_axis carries the reduced fraction and an error flag.
// Cross products are formed one 32x32 multiply per cycle on one multiplier.
// The gcd then runs Euclid's rule on a shared 64-step restoring divider, and
// the data decides how many remainders are needed (up to about 90 for 64-bit
// values). Two final exact divisions by the gcd use the same divider.
// When numerator and denominator are both zero the divider is skipped: the
// error flag is set and a zero result goes straight to the output.
// s_tready is high only while the block is idle, so one item is worked on at
// a time; the next item is taken the cycle after the result has been taken.
// The result is held in an output register until it is taken; while the
// receiver stalls the block does not accept a new item.
// Synchronous active-low reset returns the sequencer to idle and drops m_tvalid.
module rational_fraction_alu_top #(
    parameter int OPERAND_WIDTH = rfa_pkg::OPERAND_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99], pad
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // res_num[63:0], res_den[127:64]
    output logic [127:0] m_tdata,
    // zero_gcd_error
    output logic         m_tuser
);
    import rfa_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_GCD  = 7'b0000100,
        ST_GWT  = 7'b0001000,
        ST_QN   = 7'b0010000,
        ST_QD   = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] mode_reg, mode_next;
    logic signed [OPERAND_WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [1:0] step_reg, step_next;
    logic [WIDE-1:0] num_reg, num_next, den_reg, den_next;
    logic [WIDE-1:0] x_reg, x_next, y_reg, y_next;
    logic [WIDE-1:0] prod_reg;
    logic [WIDE-1:0] rn_reg, rn_next, rd_reg, rd_next;
    logic err_reg, err_next;
    logic signed [OPERAND_WIDTH-1:0] ma, mb;
    logic signed [2*OPERAND_WIDTH-1:0] mp;
    div_req_t dreq;
    div_rsp_t drsp;

    rfa_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    always_comb begin
        ma = an_reg;
        mb = bd_reg;
        case (step_reg)
            2'd0: begin ma = an_reg; mb = (mode_reg == MODE_SCALE || mode_reg == MODE_MUL)
                                          ? bn_reg : bd_reg; end
            2'd1: begin ma = bn_reg; mb = ad_reg; end
            2'd2: begin ma = ad_reg; mb = (mode_reg == MODE_DIV) ? bn_reg : bd_reg; end
            default: begin ma = an_reg; mb = bd_reg; end
        endcase
        mp = ma * mb;
    end

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        step_next  = step_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        rn_next    = rn_reg;
        rd_next    = rd_reg;
        err_next   = err_reg;
        dreq.start    = 1'b0;
        dreq.dividend = x_reg;
        dreq.divisor  = y_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mode_next  = s_tdata[2:0];
                    step_next  = 2'd0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                // Products land in prod_reg in the cycle after their step.
                step_next = step_reg + 2'd1;
                case (mode_reg)
                    MODE_SCALE: begin
                        if (step_reg == 2'd1) begin
                            num_next = prod_reg;
                            den_next = WIDE'(ad_reg);
                            state_next = ST_GCD;
                        end
                    end
                    MODE_ADD, MODE_SUB: begin
                        if (step_reg == 2'd1) num_next = prod_reg;
                        if (step_reg == 2'd2)
                            num_next = (mode_reg == MODE_SUB) ? num_reg - prod_reg
                                                              : num_reg + prod_reg;
                        if (step_reg == 2'd3) begin
                            den_next = prod_reg;
                            state_next = ST_GCD;
                        end
                    end
                    MODE_MUL, MODE_DIV: begin
                        if (step_reg == 2'd1) begin
                            num_next = prod_reg;
                            step_next = 2'd2;
                        end
                        if (step_reg == 2'd3) begin
                            den_next = prod_reg;
                            state_next = ST_GCD;
                        end
                    end
                    default: begin
                        num_next = WIDE'(an_reg);
                        den_next = WIDE'(ad_reg);
                        state_next = ST_GCD;
                    end
                endcase
                if (state_next == ST_GCD) begin
                    x_next = num_next;
                    y_next = den_next;
                end
            end
            ST_GCD: begin
                if (y_reg == '0) begin
                    if (x_reg == '0) begin
                        rn_next = '0;
                        rd_next = '0;
                        err_next = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        err_next = 1'b0;
                        dreq.start = 1'b1;
                        dreq.dividend = num_reg;
                        dreq.divisor = x_reg;
                        state_next = ST_QN;
                    end
                end else begin
                    dreq.start = 1'b1;
                    state_next = ST_GWT;
                end
            end
            ST_GWT: begin
                if (drsp.done) begin
                    x_next = y_reg;
                    y_next = drsp.rem;
                    state_next = ST_GCD;
                end
            end
            ST_QN: begin
                if (drsp.done) begin
                    rn_next = drsp.quot;
                    dreq.start = 1'b1;
                    dreq.dividend = den_reg;
                    dreq.divisor = x_reg;
                    state_next = ST_QD;
                end
            end
            ST_QD: begin
                if (drsp.done) begin
                    rd_next = drsp.quot;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        if (state_reg == ST_IDLE && s_tvalid) begin
            an_reg <= s_tdata[3 +: OPERAND_WIDTH];
            ad_reg <= s_tdata[35 +: OPERAND_WIDTH];
            bn_reg <= s_tdata[67 +: OPERAND_WIDTH];
            bd_reg <= s_tdata[99 +: OPERAND_WIDTH];
        end
        prod_reg <= WIDE'(mp);
        mode_reg <= mode_next;
        step_reg <= step_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        rn_reg   <= rn_next;
        rd_reg   <= rd_next;
        err_reg  <= err_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {rd_reg, rn_reg};
    assign m_tuser  = err_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) !(s_tready && m_tvalid))
        else $error("input ready while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> rn_reg == '0 && rd_reg == '0)
        else $error("error result not zero");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_GCD && y_reg != '0 |=> state_reg == ST_GWT)
        else $error("gcd step skipped");
endmodule

[rtl/rfa_divider.sv]
// Shared signed truncating divider, one quotient bit per cycle.
module rfa_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  rfa_pkg::div_req_t req,
    output rfa_pkg::div_rsp_t rsp
);
    import rfa_pkg::*;

    logic [WIDE-1:0] rem_reg, rem_next;
    logic [WIDE-1:0] quo_reg, quo_next;
    logic [WIDE-1:0] dvs_reg, dvs_next;
    logic [6:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic            qneg_reg, qneg_next;
    logic            rneg_reg, rneg_next;
    logic [WIDE:0]   trial;
    logic [WIDE-1:0] shifted;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[WIDE-2:0], quo_reg[WIDE-1]};
        trial     = {rem_reg, quo_reg[WIDE-1]} - {1'b0, dvs_reg};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 7'd0;
            rem_next  = '0;
            quo_next  = req.dividend[WIDE-1] ? -req.dividend : req.dividend;
            dvs_next  = req.divisor[WIDE-1] ? -req.divisor : req.divisor;
            qneg_next = req.dividend[WIDE-1] ^ req.divisor[WIDE-1];
            rneg_next = req.dividend[WIDE-1];
        end else if (busy_reg) begin
            if (!trial[WIDE]) begin
                rem_next = trial[WIDE-1:0];
                quo_next = {quo_reg[WIDE-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[WIDE-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'(WIDE - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = qneg_reg ? -quo_reg : quo_reg;
    assign rsp.rem  = rneg_reg ? -rem_reg : rem_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) rsp.done |-> !busy_reg)
        else $error("divider done while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !req.start && cnt_reg != 7'(WIDE - 1) |=> busy_reg)
        else $error("divider stopped early");
    assert property (@(posedge aclk) disable iff (!aresetn) rsp.done |=> !rsp.done)
        else $error("divider done held");
endmodule
